// ===== hw/rtl/zsr_pkg.sv =====
// Shared types and constants for the zigzag scan reorder block.
// Command and status structs between controller and datapath.
// No dependencies.
package zsr_pkg;

	// Fixed field widths
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CFG_W   = 4;

	// Controller to datapath
	typedef struct packed {
		logic load;       // write one element, advance load count
		logic scan_init;  // reset the zigzag walker
		logic scan_step;  // issue one read and advance the walker
	} zsr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_done; // the element being loaded completes the frame
		logic scan_last;  // the walker sits on the final element
	} zsr_status_t;

endpackage : zsr_pkg

// ===== hw/rtl/zsr_ctrl.sv =====
// Controller for the zigzag scan reorder: load/emit sequencing.
// Depends on zsr_pkg.
module zsr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output zsr_pkg::zsr_cmd_t    cmd,
	input  zsr_pkg::zsr_status_t status
);
	import zsr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic accept;

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;

	// Commands to the datapath
	always_comb begin
		cmd.load      = accept;
		cmd.scan_init = accept && status.frame_done;
		cmd.scan_step = (state_q == ST_EMIT);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && status.frame_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.scan_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule : zsr_ctrl

// ===== hw/rtl/zsr_datapath.sv =====
// Datapath for the zigzag scan reorder: element store, load counter,
// zigzag walker and output register. Depends on zsr_pkg.
module zsr_datapath #(
	parameter int unsigned MAX_SIDE = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [zsr_pkg::CFG_W-1:0]     cfg_data,
	input  zsr_pkg::zsr_cmd_t             cmd,
	output zsr_pkg::zsr_status_t          status,
	input  logic signed [zsr_pkg::VALUE_W-1:0] element_value,
	output logic                          result_valid,
	output logic signed [zsr_pkg::VALUE_W-1:0] scan_value,
	output logic                          last_of_frame
);
	import zsr_pkg::*;

	localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned N_W    = $clog2(MAX_SIDE + 1);
	localparam logic [CFG_W-1:0] SIDE_RST = CFG_W'(8);

	logic [CFG_W-1:0]   matrix_size_q;
	logic [N_W-1:0]     n_eff;
	logic [SIDE_W-1:0]  nm1;
	logic [CNT_W-1:0]   total;
	logic [CNT_W-1:0]   load_count_q;
	logic [CNT_W-1:0]   load_inc;
	logic [CNT_W-1:0]   k_q;
	logic [SIDE_W-1:0]  r_q;
	logic [SIDE_W-1:0]  c_q;
	logic               dir_q;     // 0: up-right, 1: down-left
	logic [ADDR_W-1:0]  rd_addr;
	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] data_s1;
	logic               valid_s1;
	logic               last_s1;

	// Side length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIDE_RST;
		end else if (cfg_wr) begin
			matrix_size_q <= cfg_data;
		end
	end

	// Clamp side to 1..MAX_SIDE
	always_comb begin
		if (matrix_size_q == '0) begin
			n_eff = N_W'(1);
		end else if (matrix_size_q > CFG_W'(MAX_SIDE)) begin
			n_eff = N_W'(MAX_SIDE);
		end else begin
			n_eff = N_W'(matrix_size_q);
		end
	end

	assign nm1   = SIDE_W'(n_eff - 1'b1);
	assign total = CNT_W'(CNT_W'(n_eff) * CNT_W'(n_eff));

	// Load counter
	assign load_inc          = load_count_q + 1'b1;
	assign status.frame_done = (load_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (cmd.load) begin
			load_count_q <= status.frame_done ? '0 : load_inc;
		end
	end

	// Element store, row-major
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[load_count_q[ADDR_W-1:0]] <= element_value;
		end
	end

	// Zigzag walker over row/column
	assign status.scan_last = (CNT_W'(k_q + 1'b1) == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			c_q   <= '0;
			dir_q <= 1'b0;
			k_q   <= '0;
		end else if (cmd.scan_init) begin
			r_q   <= '0;
			c_q   <= '0;
			dir_q <= 1'b0;
			k_q   <= '0;
		end else if (cmd.scan_step) begin
			k_q <= k_q + 1'b1;
			if (!dir_q) begin
				if (c_q == nm1) begin
					r_q   <= r_q + 1'b1;
					dir_q <= 1'b1;
				end else if (r_q == '0) begin
					c_q   <= c_q + 1'b1;
					dir_q <= 1'b1;
				end else begin
					r_q <= r_q - 1'b1;
					c_q <= c_q + 1'b1;
				end
			end else begin
				if (r_q == nm1) begin
					c_q   <= c_q + 1'b1;
					dir_q <= 1'b0;
				end else if (c_q == '0) begin
					r_q   <= r_q + 1'b1;
					dir_q <= 1'b0;
				end else begin
					r_q <= r_q + 1'b1;
					c_q <= c_q - 1'b1;
				end
			end
		end
	end

	assign rd_addr = ADDR_W'(ADDR_W'(r_q) * ADDR_W'(n_eff)) + ADDR_W'(c_q);

	// Registered read, one result per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_step;
			last_s1  <= cmd.scan_step && status.scan_last;
		end
	end

	assign result_valid  = valid_s1;
	assign scan_value    = data_s1;
	assign last_of_frame = last_s1;

`ifndef SYNTHESIS
	a_load_not_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.scan_step)
		else $error("element load during scan");
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q < CNT_W'(DEPTH))
		else $error("load count beyond store depth");
	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_frame |-> result_valid)
		else $error("last flag without result");
	a_scan_ends_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && status.scan_last) |=> !cmd.scan_step)
		else $error("scan continued past final element");
`endif

endmodule : zsr_datapath

// ===== hw/rtl/zigzag_scan_reorder.sv =====
// Top level of the zigzag scan reorder block.
// Instantiates zsr_ctrl and zsr_datapath; depends on zsr_pkg.

// Elements of an n x n matrix enter one per cycle in row-major order while busy is
// low; n is the matrix_size register (0 is taken as 1, values above MAX_SIDE as
// MAX_SIDE). The element that completes a frame raises busy, and the frame then
// leaves in zigzag order, one result per cycle on result_valid, from the read
// register that follows the emit state; last_of_frame marks the final one. The
// receiver cannot stall, so every strobe must be captured. Loading and emission
// of a frame do not overlap, and emission is bounded by the single read port of
// the element store; busy drops in the cycle the last result shows.
// Configuration writes are always taken but must only be made between frames.
module zigzag_scan_reorder #(
	parameter int unsigned MAX_SIDE = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [zsr_pkg::VALUE_W-1:0] element_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [zsr_pkg::CFG_W-1:0]          cfg_data,
	output logic                               result_valid,
	output logic signed [zsr_pkg::VALUE_W-1:0] scan_value,
	output logic                               last_of_frame
);
	import zsr_pkg::*;

	zsr_cmd_t    cmd;
	zsr_status_t status;

	assign cfg_ready = 1'b1;

	// Sequencing
	zsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	// Store, walker and output register
	zsr_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.element_value (element_value),
		.result_valid  (result_valid),
		.scan_value    (scan_value),
		.last_of_frame (last_of_frame)
	);

endmodule : zigzag_scan_reorder
